// ===== design/zdr_pkg.sv =====
// ----------------------------------------------------------------------------
// zdr_pkg: shared types and constants
// Item layouts, lane control structs, fixed-point helpers and the CORDIC
// arctangent table for the dead-reckoning filter.
// ----------------------------------------------------------------------------
package zdr_pkg;

    localparam int NUM_AXES = 3;

    localparam logic [31:0] ONE_Q24     = 32'd16777216;
    localparam logic [32:0] CORDIC_GAIN = 33'd39797;
    localparam logic [32:0] G_Q16       = 33'd642908;
    localparam logic [24:0] DT_RECIP    = 25'd17592187;
    localparam logic [13:0] DT_DIV      = 14'd15625;
    localparam logic [23:0] DT_BIAS     = 24'd7812;

    localparam logic [1:0] ST_WARM = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;

    localparam logic [2:0] CFG_DEADBAND = 3'd0;
    localparam logic [2:0] CFG_QNOISE   = 3'd1;
    localparam logic [2:0] CFG_RNOISE   = 3'd2;
    localparam logic [2:0] CFG_SDECAY   = 3'd3;
    localparam logic [2:0] CFG_MDECAY   = 3'd4;
    localparam logic [2:0] CFG_MAXINT   = 3'd5;
    localparam logic [2:0] CFG_WARMUP   = 3'd6;

    typedef logic signed [51:0] t_wide;
    typedef logic signed [65:0] t_prod;

    localparam t_wide SAT_HI = 52'sd2147483647;
    localparam t_wide SAT_LO = -52'sd2147483648;

    typedef struct packed {
        logic [23:0]        interval_us;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] heading;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic signed [31:0] position_z;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
        logic signed [31:0] velocity_z;
        logic [1:0]         step_status;
    } t_out_item;

    typedef struct packed {
        logic [14:0] deadband;
        logic [30:0] q_noise;
        logic [30:0] r_noise;
        logic [15:0] sdecay;
        logic [15:0] mdecay;
    } t_lane_cfg;

    typedef struct packed {
        logic               start;
        logic               use_gain;
        logic signed [32:0] drive;
        logic signed [15:0] raw;
        logic [20:0]        dt;
    } t_lane_req;

    typedef struct packed {
        logic               busy;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
    } t_lane_sts;

    function automatic t_prod rnd_shift(input t_prod v, input int unsigned s);
        return (v + (t_prod'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input t_wide v);
        logic signed [31:0] res;
        if (v > SAT_HI) begin
            res = 32'sh7FFFFFFF;
        end else if (v < SAT_LO) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic [13:0] atan_step(input logic [3:0] i);
        logic [13:0] res;
        case (i)
            4'd0:    res = 14'd8192;
            4'd1:    res = 14'd4836;
            4'd2:    res = 14'd2555;
            4'd3:    res = 14'd1297;
            4'd4:    res = 14'd651;
            4'd5:    res = 14'd326;
            4'd6:    res = 14'd163;
            4'd7:    res = 14'd81;
            4'd8:    res = 14'd41;
            4'd9:    res = 14'd20;
            4'd10:   res = 14'd10;
            4'd11:   res = 14'd5;
            4'd12:   res = 14'd3;
            4'd13:   res = 14'd1;
            4'd14:   res = 14'd1;
            default: res = 14'd0;
        endcase
        return res;
    endfunction

endpackage

// ===== design/zdr_if.sv =====
// ----------------------------------------------------------------------------
// zdr_if: stream channels
// Valid/ready channels for IMU samples and filter results.
// ----------------------------------------------------------------------------
interface zdr_smp_if;
    import zdr_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface zdr_res_if;
    import zdr_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/zupt_kalman_dead_reckoning.sv =====
// ----------------------------------------------------------------------------
// zupt_kalman_dead_reckoning: three-axis dead reckoning filter
// Rotates body accelerations by heading and runs a position/velocity Kalman
// filter with zero-velocity updates on each axis in parallel lanes.
// ----------------------------------------------------------------------------
// Warm-up and skipped samples go from the transfer to the emit state, where the
// result is registered once the output is free. Updated samples pass the 16-step
// heading rotation and lane prediction sequence, and the six divisions of the lane
// update when any axis is stationary; one sample is in flight at a time.
// Synchronous active-low reset restores filter state, time and registers.
module zupt_kalman_dead_reckoning (
    input  logic       i_clk,
    input  logic       i_rst_n,
    zdr_smp_if.sink    i_smp,
    zdr_res_if.source  o_res,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [30:0] i_cfg_data
);
    import zdr_pkg::*;

    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_CALC  = 3'd1;
    localparam logic [2:0] T_WAIT  = 3'd2;
    localparam logic [2:0] T_LANE  = 3'd3;
    localparam logic [2:0] T_LWAIT = 3'd4;
    localparam logic [2:0] T_EMIT  = 3'd5;

    logic [2:0]         r_state;
    logic [14:0]        r_deadband;
    logic [30:0]        r_qn;
    logic [30:0]        r_rn;
    logic [15:0]        r_sdec;
    logic [15:0]        r_mdec;
    logic [23:0]        r_maxi;
    logic [23:0]        r_warm;
    logic [23:0]        r_tss;
    logic [23:0]        r_interval;
    logic signed [15:0] r_ax;
    logic signed [15:0] r_ay;
    logic signed [15:0] r_az;
    logic signed [15:0] r_hd;
    logic [1:0]         r_status;
    logic [20:0]        r_dt;
    logic [10:0]        r_dq;
    logic [13:0]        r_drem;
    logic [10:0]        r_dlo;
    logic               r_ovalid;
    t_out_item          r_out;

    logic [24:0]        tsum;
    logic [23:0]        n_tss;
    logic [48:0]        dq_prod;
    logic [23:0]        dq_back;
    logic [13:0]        dq_rem;
    logic [23:0]        dlo_x;
    logic [48:0]        dlo_prod;
    logic               rot_busy;
    logic signed [32:0] rot_x;
    logic signed [32:0] rot_y;
    logic               lane_busy_any;
    logic               emit_ok;
    t_lane_cfg          lane_cfg;
    t_lane_sts          lane_sts [3];
    logic signed [32:0] drive_all [3];
    logic signed [15:0] raw_all [3];
    logic               gain_all [3];

    assign tsum  = {1'b0, r_tss} + {1'b0, i_smp.data.interval_us};
    assign n_tss = tsum[24] ? 24'hFFFFFF : tsum[23:0];
    assign i_smp.ready = (r_state == T_IDLE);
    assign emit_ok = !r_ovalid || o_res.ready;

    // The interval in Q16.16 seconds is split into whole and partial parts of
    // 15625 microseconds, each divided by reciprocal multiplication.
    assign dq_prod  = {25'd0, r_interval} * {24'd0, DT_RECIP};
    assign dq_back  = {13'd0, r_dq} * {10'd0, DT_DIV};
    assign dq_rem   = 14'(r_interval - dq_back);
    assign dlo_x    = {r_drem, 10'd0} + DT_BIAS;
    assign dlo_prod = {25'd0, dlo_x} * {24'd0, DT_RECIP};

    always_ff @(posedge i_clk) begin
        r_dq   <= dq_prod[48:38];
        r_drem <= dq_rem;
        r_dlo  <= dlo_prod[48:38];
    end

    zdr_rotate u_rot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == T_CALC),
        .i_ax      (r_ax),
        .i_ay      (r_ay),
        .i_heading (r_hd),
        .o_busy    (rot_busy),
        .o_x       (rot_x),
        .o_y       (rot_y)
    );

    assign lane_cfg.deadband = r_deadband;
    assign lane_cfg.q_noise  = r_qn;
    assign lane_cfg.r_noise  = r_rn;
    assign lane_cfg.sdecay   = r_sdec;
    assign lane_cfg.mdecay   = r_mdec;

    assign drive_all[0] = rot_x;
    assign drive_all[1] = rot_y;
    assign drive_all[2] = 33'(r_az) <<< 14;
    assign raw_all[0]   = r_ax;
    assign raw_all[1]   = r_ay;
    assign raw_all[2]   = r_az;
    assign gain_all[0]  = 1'b1;
    assign gain_all[1]  = 1'b1;
    assign gain_all[2]  = 1'b0;

    for (genvar a = 0; a < 3; a++) begin : g_lane
        if (a < NUM_AXES) begin : g_on
            t_lane_req req;
            assign req.start    = (r_state == T_LANE);
            assign req.use_gain = gain_all[a];
            assign req.drive    = drive_all[a];
            assign req.raw      = raw_all[a];
            assign req.dt       = r_dt;
            zdr_axis u_axis (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cfg   (lane_cfg),
                .i_req   (req),
                .o_sts   (lane_sts[a])
            );
        end else begin : g_off
            assign lane_sts[a] = '0;
        end
    end

    assign lane_busy_any = lane_sts[0].busy | lane_sts[1].busy | lane_sts[2].busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= 15'd246;
            r_qn       <= 31'd16777;
            r_rn       <= 31'd167772;
            r_sdec     <= 16'd55706;
            r_mdec     <= 16'd64225;
            r_maxi     <= 24'd100000;
            r_warm     <= 24'd3000000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEADBAND: r_deadband <= i_cfg_data[14:0];
                CFG_QNOISE:   r_qn       <= i_cfg_data;
                CFG_RNOISE:   r_rn       <= i_cfg_data;
                CFG_SDECAY:   r_sdec     <= i_cfg_data[15:0];
                CFG_MDECAY:   r_mdec     <= i_cfg_data[15:0];
                CFG_MAXINT:   r_maxi     <= i_cfg_data[23:0];
                CFG_WARMUP:   r_warm     <= i_cfg_data[23:0];
                default:      r_deadband <= r_deadband;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_tss    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == T_EMIT && emit_ok) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                T_IDLE: begin
                    if (i_smp.valid) begin
                        r_tss      <= n_tss;
                        r_interval <= i_smp.data.interval_us;
                        r_ax       <= i_smp.data.accel_x;
                        r_ay       <= i_smp.data.accel_y;
                        r_az       <= i_smp.data.accel_z;
                        r_hd       <= i_smp.data.heading;
                        if (n_tss < r_warm) begin
                            r_status <= ST_WARM;
                            r_state  <= T_EMIT;
                        end else if (i_smp.data.interval_us > r_maxi) begin
                            r_status <= ST_SKIP;
                            r_state  <= T_EMIT;
                        end else begin
                            r_status <= ST_UPD;
                            r_state  <= T_CALC;
                        end
                    end
                end
                T_CALC: begin
                    r_state <= T_WAIT;
                end
                T_WAIT: begin
                    if (!rot_busy) begin
                        r_dt    <= {r_dq, 10'd0} + {10'd0, r_dlo};
                        r_state <= T_LANE;
                    end
                end
                T_LANE: begin
                    r_state <= T_LWAIT;
                end
                T_LWAIT: begin
                    if (!lane_busy_any) begin
                        r_state <= T_EMIT;
                    end
                end
                T_EMIT: begin
                    if (emit_ok) begin
                        r_state <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == T_EMIT && emit_ok) begin
            r_out.step_status <= r_status;
            if (r_status == ST_WARM) begin
                r_out.position_x <= '0;
                r_out.position_y <= '0;
                r_out.position_z <= '0;
                r_out.velocity_x <= '0;
                r_out.velocity_y <= '0;
                r_out.velocity_z <= '0;
            end else begin
                r_out.position_x <= lane_sts[0].pos;
                r_out.position_y <= lane_sts[1].pos;
                r_out.position_z <= lane_sts[2].pos;
                r_out.velocity_x <= lane_sts[0].vel;
                r_out.velocity_y <= lane_sts[1].vel;
                r_out.velocity_z <= lane_sts[2].vel;
            end
        end
    end

    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_out;

`ifndef SYNTHESIS
    a_idle_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_IDLE) |-> !lane_busy_any)
        else $error("filter lane busy while idle");

    a_lane_inputs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_LANE) |-> !rot_busy)
        else $error("lanes started before rotation settled");

    a_warm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.step_status == ST_WARM) |->
        (o_res.data.position_x == 0 && o_res.data.position_y == 0 &&
         o_res.data.position_z == 0 && o_res.data.velocity_x == 0 &&
         o_res.data.velocity_y == 0 && o_res.data.velocity_z == 0))
        else $error("nonzero result during warm-up");

    a_time_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_tss >= $past(r_tss)))
        else $error("elapsed time decreased");
`endif
endmodule

// ===== design/zdr_div.sv =====
// ----------------------------------------------------------------------------
// zdr_div: restoring divider
// Unsigned 64 by 33 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module zdr_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_busy,
    output logic [63:0] o_quo
);
    logic [63:0] r_num;
    logic [32:0] r_rem;
    logic [32:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [33:0] rem_sh;
    logic [33:0] diff;

    assign rem_sh = {r_rem, r_num[63]};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!diff[33]) begin
                r_rem <= diff[32:0];
                r_num <= {r_num[62:0], 1'b1};
            end else begin
                r_rem <= rem_sh[32:0];
                r_num <= {r_num[62:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_num;
endmodule

// ===== design/zdr_rotate.sv =====
// ----------------------------------------------------------------------------
// zdr_rotate: heading rotation
// Quarter-turn rotation followed by sixteen CORDIC steps, one per cycle.
// ----------------------------------------------------------------------------
module zdr_rotate (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_ax,
    input  logic signed [15:0] i_ay,
    input  logic signed [15:0] i_heading,
    output logic               o_busy,
    output logic signed [32:0] o_x,
    output logic signed [32:0] o_y
);
    import zdr_pkg::*;

    logic signed [32:0] r_x;
    logic signed [32:0] r_y;
    logic signed [16:0] r_z;
    logic [3:0]         r_i;
    logic               r_busy;
    logic [15:0]        h;
    logic signed [32:0] ax_s;
    logic signed [32:0] ay_s;
    logic signed [32:0] x0;
    logic signed [32:0] y0;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [16:0] da;

    assign h    = i_heading + 16'h2000;
    assign ax_s = 33'(i_ax) <<< 14;
    assign ay_s = 33'(i_ay) <<< 14;
    assign dx   = r_y >>> r_i;
    assign dy   = r_x >>> r_i;
    assign da   = $signed({3'b000, atan_step(r_i)});

    always_comb begin
        case (h[15:14])
            2'd0: begin
                x0 = ax_s;
                y0 = ay_s;
            end
            2'd1: begin
                x0 = -ay_s;
                y0 = ax_s;
            end
            2'd2: begin
                x0 = -ax_s;
                y0 = -ay_s;
            end
            default: begin
                x0 = ay_s;
                y0 = -ax_s;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
        end else if (r_busy) begin
            r_i <= r_i + 4'd1;
            if (r_i == 4'd15) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= x0;
            r_y <= y0;
            r_z <= $signed({3'b000, h[13:0]}) - 17'sd8192;
        end else if (r_busy) begin
            if (!r_z[16]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - da;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + da;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_x    = r_x;
    assign o_y    = r_y;
endmodule

// ===== design/zdr_axis.sv =====
// ----------------------------------------------------------------------------
// zdr_axis: one filter lane
// Drive scaling, position/velocity prediction, zero-velocity update and
// velocity decay for one axis, sequenced over a shared multiplier and divider.
// ----------------------------------------------------------------------------
module zdr_axis (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  zdr_pkg::t_lane_cfg i_cfg,
    input  zdr_pkg::t_lane_req i_req,
    output zdr_pkg::t_lane_sts o_sts
);
    import zdr_pkg::*;

    localparam logic [4:0] L_IDLE = 5'd0;
    localparam logic [4:0] L_GAIN = 5'd1;
    localparam logic [4:0] L_EG   = 5'd2;
    localparam logic [4:0] L_UM   = 5'd3;
    localparam logic [4:0] L_UU   = 5'd4;
    localparam logic [4:0] L_HD   = 5'd5;
    localparam logic [4:0] L_P1   = 5'd6;
    localparam logic [4:0] L_P2   = 5'd7;
    localparam logic [4:0] L_P3   = 5'd8;
    localparam logic [4:0] L_P4   = 5'd9;
    localparam logic [4:0] L_P5   = 5'd10;
    localparam logic [4:0] L_P6   = 5'd11;
    localparam logic [4:0] L_P7   = 5'd12;
    localparam logic [4:0] L_ZM   = 5'd13;
    localparam logic [4:0] L_ZS   = 5'd14;
    localparam logic [4:0] L_ZW   = 5'd15;
    localparam logic [4:0] L_DM   = 5'd16;
    localparam logic [4:0] L_DV   = 5'd17;

    localparam logic [2:0] K_POS = 3'd0;
    localparam logic [2:0] K_VEL = 3'd1;
    localparam logic [2:0] K_P00 = 3'd2;
    localparam logic [2:0] K_P10 = 3'd3;
    localparam logic [2:0] K_P01 = 3'd4;
    localparam logic [2:0] K_P11 = 3'd5;

    logic [4:0]         r_state;
    logic signed [31:0] r_p;
    logic signed [31:0] r_v;
    logic signed [31:0] r_p00;
    logic signed [31:0] r_p01;
    logic signed [31:0] r_p10;
    logic signed [31:0] r_p11;
    logic signed [32:0] r_e;
    logic signed [31:0] r_u;
    logic [24:0]        r_hdt2;
    t_wide              r_acc;
    logic signed [31:0] r_pp;
    logic signed [31:0] r_pv;
    logic signed [31:0] r_c00;
    logic signed [31:0] r_c01;
    logic signed [31:0] r_c10;
    logic signed [31:0] r_c11;
    logic [32:0]        r_s;
    logic [2:0]         r_k;
    logic               r_zupt;
    logic               r_neg;
    t_prod              r_prod;

    logic signed [32:0] opa;
    logic signed [32:0] opb;
    logic signed [32:0] dt_s;
    logic signed [32:0] y_s;
    t_wide              rs16;
    t_wide              qn_w;
    logic signed [32:0] s_c;
    logic [16:0]        raw_s;
    logic [16:0]        mag;
    logic               zupt_c;
    t_prod              pmag;
    logic [63:0]        div_num;
    logic               div_busy;
    logic [63:0]        div_quo;
    logic [33:0]        qc;
    t_wide              qv;

    assign dt_s   = $signed({12'd0, i_req.dt});
    assign y_s    = -33'(r_pv);
    assign rs16   = t_wide'(rnd_shift(r_prod, 16));
    assign qn_w   = $signed({21'd0, i_cfg.q_noise});
    assign s_c    = 33'(r_c11) + $signed({2'b00, i_cfg.r_noise});
    assign raw_s  = {i_req.raw[15], i_req.raw};
    assign mag    = i_req.raw[15] ? (17'd0 - raw_s) : raw_s;
    assign zupt_c = mag < {2'b00, i_cfg.deadband};
    assign pmag   = r_prod[65] ? -r_prod : r_prod;
    assign div_num = pmag[63:0] + {32'd0, r_s[32:1]};
    assign qc     = (|div_quo[63:33]) ? {1'b1, 33'd0} : div_quo[33:0];
    assign qv     = r_neg ? -$signed({18'd0, qc}) : $signed({18'd0, qc});

    zdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == L_ZS),
        .i_num   (div_num),
        .i_den   (r_s),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    always_comb begin
        opa = '0;
        opb = '0;
        case (r_state)
            L_GAIN: begin
                opa = i_req.drive;
                opb = $signed(CORDIC_GAIN);
            end
            L_UM: begin
                opa = r_e;
                opb = $signed(G_Q16);
            end
            L_UU: begin
                opa = dt_s;
                opb = dt_s;
            end
            L_HD: begin
                opa = 33'(r_v);
                opb = dt_s;
            end
            L_P1: begin
                opa = $signed({8'd0, r_hdt2});
                opb = 33'(r_u);
            end
            L_P2: begin
                opa = dt_s;
                opb = 33'(r_u);
            end
            L_P3: begin
                opa = dt_s;
                opb = 33'(r_p10);
            end
            L_P4: begin
                opa = dt_s;
                opb = 33'(r_p11);
            end
            L_P6: begin
                opa = 33'(r_c01);
                opb = dt_s;
            end
            L_ZM: begin
                case (r_k)
                    K_POS: begin
                        opa = 33'(r_c01);
                        opb = y_s;
                    end
                    K_VEL: begin
                        opa = 33'(r_c11);
                        opb = y_s;
                    end
                    K_P00: begin
                        opa = 33'(r_c01);
                        opb = 33'(r_c10);
                    end
                    K_P10: begin
                        opa = 33'(r_c11);
                        opb = 33'(r_c10);
                    end
                    K_P01: begin
                        opa = 33'(r_c01);
                        opb = 33'(r_c11);
                    end
                    default: begin
                        opa = 33'(r_c11);
                        opb = 33'(r_c11);
                    end
                endcase
            end
            L_DM: begin
                opa = 33'(r_pv);
                opb = $signed({17'd0, r_zupt ? i_cfg.sdecay : i_cfg.mdecay});
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= opa * opb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_p     <= '0;
            r_v     <= '0;
            r_p00   <= ONE_Q24;
            r_p01   <= '0;
            r_p10   <= '0;
            r_p11   <= ONE_Q24;
        end else begin
            case (r_state)
                L_IDLE: begin
                    if (i_req.start) begin
                        if (i_req.use_gain) begin
                            r_state <= L_GAIN;
                        end else begin
                            r_e     <= i_req.drive;
                            r_state <= L_UM;
                        end
                    end
                end
                L_GAIN: begin
                    r_state <= L_EG;
                end
                L_EG: begin
                    r_e     <= 33'(rnd_shift(r_prod, 16));
                    r_state <= L_UM;
                end
                L_UM: begin
                    r_state <= L_UU;
                end
                L_UU: begin
                    r_u     <= sat32(t_wide'(rnd_shift(r_prod, 25)));
                    r_state <= L_HD;
                end
                L_HD: begin
                    r_hdt2  <= 25'(rnd_shift(r_prod, 17));
                    r_state <= L_P1;
                end
                L_P1: begin
                    r_acc   <= rs16;
                    r_state <= L_P2;
                end
                L_P2: begin
                    r_pp    <= sat32(t_wide'(r_p) + r_acc + rs16);
                    r_state <= L_P3;
                end
                L_P3: begin
                    r_pv    <= sat32(t_wide'(r_v) + rs16);
                    r_state <= L_P4;
                end
                L_P4: begin
                    r_c00   <= sat32(t_wide'(r_p00) + rs16);
                    r_state <= L_P5;
                end
                L_P5: begin
                    r_c01   <= sat32(t_wide'(r_p01) + rs16);
                    r_c10   <= sat32(t_wide'(r_p10) + rs16);
                    r_c11   <= sat32(t_wide'(r_p11) + qn_w);
                    r_state <= L_P6;
                end
                L_P6: begin
                    r_state <= L_P7;
                end
                L_P7: begin
                    r_c00  <= sat32(t_wide'(r_c00) + rs16 + qn_w);
                    r_zupt <= zupt_c;
                    r_s    <= s_c;
                    r_k    <= K_POS;
                    if (zupt_c && !s_c[32] && (s_c != 33'sd0)) begin
                        r_state <= L_ZM;
                    end else begin
                        r_state <= L_DM;
                    end
                end
                L_ZM: begin
                    r_state <= L_ZS;
                end
                L_ZS: begin
                    r_neg   <= r_prod[65];
                    r_state <= L_ZW;
                end
                L_ZW: begin
                    if (!div_busy) begin
                        case (r_k)
                            K_POS:   r_pp  <= sat32(t_wide'(r_pp) + qv);
                            K_VEL:   r_pv  <= sat32(t_wide'(r_pv) + qv);
                            K_P00:   r_c00 <= sat32(t_wide'(r_c00) - qv);
                            K_P10:   r_c10 <= sat32(t_wide'(r_c10) - qv);
                            K_P01:   r_c01 <= sat32(t_wide'(r_c01) - qv);
                            default: r_c11 <= sat32(t_wide'(r_c11) - qv);
                        endcase
                        if (r_k == K_P11) begin
                            r_state <= L_DM;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= L_ZM;
                        end
                    end
                end
                L_DM: begin
                    r_state <= L_DV;
                end
                L_DV: begin
                    r_v     <= sat32(rs16);
                    r_p     <= r_pp;
                    r_p00   <= r_c00;
                    r_p01   <= r_c01;
                    r_p10   <= r_c10;
                    r_p11   <= r_c11;
                    r_state <= L_IDLE;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_sts.busy = (r_state != L_IDLE);
    assign o_sts.pos  = r_p;
    assign o_sts.vel  = r_v;
endmodule
